/* design/assert_macros.svh */
// Assertion helpers used by the RTL file isq_core.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ISQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define ISQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* design/isq_pkg.sv */
`default_nettype none

package isq_pkg;

  localparam int MV_W       = 12;
  localparam int MS_W       = 32;
  localparam int PER_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ON_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ON_DB   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DB  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WARN    = 3'd5;

  localparam logic [MV_W-1:0]  ON_THR_RST  = 12'd2500;
  localparam logic [MV_W-1:0]  OFF_THR_RST = 12'd600;
  localparam logic [MS_W-1:0]  ON_DB_RST   = 32'd3000;
  localparam logic [MS_W-1:0]  OFF_DB_RST  = 32'd20000;
  localparam logic [PER_W-1:0] PERIOD_RST  = 16'd250;
  localparam logic [MS_W-1:0]  WARN_RST    = 32'd120000;

  typedef enum logic [1:0] {
    CLS_UNKNOWN = 2'd0,
    CLS_ON      = 2'd1,
    CLS_OFF     = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    EVT_NONE = 2'd0,
    EVT_ON   = 2'd1,
    EVT_OFF  = 2'd2
  } evt_t;

  typedef struct packed {
    logic [MV_W-1:0]  on_thr_mv;
    logic [MV_W-1:0]  off_thr_mv;
    logic [MS_W-1:0]  on_db_ms;
    logic [MS_W-1:0]  off_db_ms;
    logic [PER_W-1:0] period_ms;
    logic [MS_W-1:0]  warn_ms;
  } cfg_t;

  typedef struct packed {
    logic accepted;
    cls_t ignition_state;
    evt_t transition_event;
    logic midzone_warning;
  } res_t;

endpackage

`default_nettype wire

/* design/isq_ifs.sv */
`default_nettype none

interface isq_in_if;
  import isq_pkg::*;

  logic            valid;
  logic            ready;
  logic [MV_W-1:0] pin_mv;
  logic [MS_W-1:0] time_ms;

  modport source (output valid, output pin_mv, output time_ms, input ready);
  modport sink   (input valid, input pin_mv, input time_ms, output ready);
endinterface

interface isq_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [1:0] ignition_state;
  logic [1:0] transition_event;
  logic       midzone_warning;

  modport source (output valid, output accepted, output ignition_state,
                  output transition_event, output midzone_warning, input ready);
  modport sink   (input valid, input accepted, input ignition_state,
                  input transition_event, input midzone_warning, output ready);
endinterface

`default_nettype wire

/* design/isq_core.sv */
`default_nettype none
`include "assert_macros.svh"

module isq_core (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire logic [isq_pkg::MV_W-1:0] pin_mv,
  input  wire logic [isq_pkg::MS_W-1:0] time_ms,
  input  wire isq_pkg::cfg_t            cfg,
  output isq_pkg::res_t                 res
);
  import isq_pkg::*;

  cls_t            qstate_r;
  cls_t            cand_r;
  logic [MS_W-1:0] cand_start_r;
  logic [MS_W-1:0] last_r;
  logic [MS_W-1:0] mz_start_r;
  logic            mz_run_r;
  logic            mz_warned_r;

  logic [MS_W-1:0] gap;
  logic [MS_W-1:0] mz_el;
  logic [MS_W-1:0] cand_el;
  logic [MS_W-1:0] need;
  logic            acc;
  logic            mz;
  logic            warn;
  logic            adopt;
  cls_t            cls;

  always_comb begin
    gap     = time_ms - last_r;
    mz_el   = time_ms - mz_start_r;
    cand_el = time_ms - cand_start_r;
    acc     = gap >= {{(MS_W-PER_W){1'b0}}, cfg.period_ms};
    if (pin_mv >= cfg.on_thr_mv) begin
      cls = CLS_ON;
    end else if (pin_mv <= cfg.off_thr_mv) begin
      cls = CLS_OFF;
    end else begin
      cls = CLS_UNKNOWN;
    end
    mz    = (cls == CLS_UNKNOWN);
    need  = (cls == CLS_ON) ? cfg.on_db_ms : cfg.off_db_ms;
    warn  = acc && mz && mz_run_r && !mz_warned_r && (mz_el >= cfg.warn_ms);
    adopt = acc && !mz && (cls == cand_r) && (cls != qstate_r) && (cand_el >= need);

    res.accepted         = acc;
    res.ignition_state   = adopt ? cls : qstate_r;
    res.transition_event = !adopt ? EVT_NONE : ((cls == CLS_ON) ? EVT_ON : EVT_OFF);
    res.midzone_warning  = warn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qstate_r     <= CLS_UNKNOWN;
      cand_r       <= CLS_UNKNOWN;
      cand_start_r <= '0;
      last_r       <= '0;
      mz_start_r   <= '0;
      mz_run_r     <= 1'b0;
      mz_warned_r  <= 1'b0;
    end else if (adv && acc) begin
      last_r <= time_ms;
      if (mz) begin
        if (!mz_run_r) begin
          mz_run_r   <= 1'b1;
          mz_start_r <= time_ms;
        end else if (warn) begin
          mz_warned_r <= 1'b1;
        end
      end else begin
        mz_run_r    <= 1'b0;
        mz_start_r  <= '0;
        mz_warned_r <= 1'b0;
        if (cls != cand_r) begin
          cand_r       <= cls;
          cand_start_r <= time_ms;
        end else if (adopt) begin
          qstate_r <= cls;
        end
      end
    end
  end

  `ISQ_ASSERT(a_evt_on_state, (adv && res.transition_event == EVT_ON) |=> (qstate_r == CLS_ON), "engine-on event without on state")
  `ISQ_ASSERT(a_evt_off_state, (adv && res.transition_event == EVT_OFF) |=> (qstate_r == CLS_OFF), "engine-off event without off state")
  `ISQ_ASSERT(a_warn_latch, (adv && res.midzone_warning) |=> (mz_warned_r && mz_run_r), "midzone warning not latched")
  `ISQ_ASSERT(a_reject_hold, (adv && !res.accepted) |=> ($stable(last_r) && $stable(qstate_r)), "rejected item changed state")
  `ISQ_ASSERT_ALWAYS(a_warn_needs_run, (rst_n && adv && res.midzone_warning) |-> (mz_run_r && !mz_warned_r), "warning outside an armed midzone")

endmodule

`default_nettype wire

/* design/ignition_sense_qualifier_top.sv */
// Ignition sense qualifier. Takes one item (pin millivolts, wrapping ms timestamp) per clock
// unless the result side stalls, and returns exactly one result item per input item: whether
// the sample passed the sample period gate, the debounced ignition state (unknown/on/off),
// an engine-on/off event on the item that changes the state, and a one-time midzone warning.
// Throughput is one item per cycle unless out_item.ready stalls; items pass through an input
// register and a result register; unused cfg indexes are ignored. The cycle time is set by
// the 32-bit timestamp subtract-and-compare feeding the state update. The user must write
// registers through cfg_we/cfg_index/cfg_wdata only while no item is in flight (not enforced).
`default_nettype none

module ignition_sense_qualifier_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  isq_in_if.sink                              in_item,
  isq_out_if.source                           out_item,
  input  wire logic                           cfg_we,
  input  wire logic [isq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [isq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import isq_pkg::*;

  cfg_t            cfg_r;
  logic            s1_vld_r;
  logic [MV_W-1:0] s1_pin_r;
  logic [MS_W-1:0] s1_time_r;
  logic            out_vld_r;
  res_t            out_res_r;
  res_t            res;
  logic            out_free;
  logic            s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_thr_mv  <= ON_THR_RST;
      cfg_r.off_thr_mv <= OFF_THR_RST;
      cfg_r.on_db_ms   <= ON_DB_RST;
      cfg_r.off_db_ms  <= OFF_DB_RST;
      cfg_r.period_ms  <= PERIOD_RST;
      cfg_r.warn_ms    <= WARN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ON_THR:  cfg_r.on_thr_mv  <= cfg_wdata[MV_W-1:0];
        REG_OFF_THR: cfg_r.off_thr_mv <= cfg_wdata[MV_W-1:0];
        REG_ON_DB:   cfg_r.on_db_ms   <= cfg_wdata[MS_W-1:0];
        REG_OFF_DB:  cfg_r.off_db_ms  <= cfg_wdata[MS_W-1:0];
        REG_PERIOD:  cfg_r.period_ms  <= cfg_wdata[PER_W-1:0];
        REG_WARN:    cfg_r.warn_ms    <= cfg_wdata[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free      = !out_vld_r || out_item.ready;
  assign s1_adv        = s1_vld_r && out_free;
  assign in_item.ready = !s1_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_item.ready) begin
      s1_vld_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      s1_pin_r  <= in_item.pin_mv;
      s1_time_r <= in_item.time_ms;
    end
  end

  isq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (s1_adv),
    .pin_mv  (s1_pin_r),
    .time_ms (s1_time_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_item.valid            = out_vld_r;
  assign out_item.accepted         = out_res_r.accepted;
  assign out_item.ignition_state   = out_res_r.ignition_state;
  assign out_item.transition_event = out_res_r.transition_event;
  assign out_item.midzone_warning  = out_res_r.midzone_warning;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

module tb;
  import isq_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PER_PHASE   = 190;
  localparam int unsigned NUM_PHASES  = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [31:0]           a;
    logic [31:0]           b;
    logic                  typed;
    res_t                  want;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  isq_in_if  in_if ();
  isq_out_if out_if ();

  ignition_sense_qualifier_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_if),
    .out_item  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // item: pin_mv in a, time_ms in b; config: register in idx, value in a
  row_t directed_rows [29] = '{
    '{ROW_ITEM, '0, 32'd4095, 32'd0, 1'b1, '{1'b0, CLS_UNKNOWN, EVT_NONE, 1'b0}},
    '{ROW_ITEM, '0, 32'd0, 32'd249, 1'b1, '{1'b0, CLS_UNKNOWN, EVT_NONE, 1'b0}},
    '{ROW_ITEM, '0, 32'd4095, 32'd250, 1'b1, '{1'b1, CLS_UNKNOWN, EVT_NONE, 1'b0}},
    '{ROW_ITEM, '0, 32'd4095, 32'd300, 1'b1, '{1'b0, CLS_UNKNOWN, EVT_NONE, 1'b0}},
    '{ROW_ITEM, '0, 32'd2500, 32'd3250, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd2499, 32'd3500, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd601, 32'd123500, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd1500, 32'd250000, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd600, 32'd250250, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd0, 32'd270249, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd0, 32'd270250, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd4095, 32'hFFFF_FF00, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd4095, 32'h0000_0B00, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd4095, 32'h0000_0B64, 1'b1, '{1'b0, CLS_ON, EVT_NONE, 1'b0}},
    '{ROW_CFG, REG_PERIOD, 32'd0, 32'd0, 1'b0, '0},
    '{ROW_CFG, REG_WARN, 32'd0, 32'd0, 1'b0, '0},
    '{ROW_CFG, REG_ON_DB, 32'd0, 32'd0, 1'b0, '0},
    '{ROW_CFG, REG_OFF_DB, 32'd0, 32'd0, 1'b0, '0},
    '{ROW_CFG, REG_SPARE_LO, 32'hFFFF_FFFF, 32'd0, 1'b0, '0},
    '{ROW_CFG, REG_SPARE_HI, 32'hFFFF_FFFF, 32'd0, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd1000, 32'h0000_0B64, 1'b1, '{1'b1, CLS_ON, EVT_NONE, 1'b0}},
    '{ROW_ITEM, '0, 32'd1000, 32'h0000_0B64, 1'b1, '{1'b1, CLS_ON, EVT_NONE, 1'b1}},
    '{ROW_ITEM, '0, 32'd0, 32'h0000_0B64, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd0, 32'h0000_0B64, 1'b0, '0},
    '{ROW_CFG, REG_ON_THR, 32'd0, 32'd0, 1'b0, '0},
    '{ROW_CFG, REG_OFF_THR, 32'd4095, 32'd0, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd0, 32'h0000_0B65, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd4095, 32'h0000_0B66, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd2048, 32'h0000_0B67, 1'b0, '0}
  };

  cfg_t phase_cfg [NUM_PHASES] = '{
    '{12'd2000, 12'd1000, 32'd40, 32'd150, 16'd10, 32'd200},
    '{12'd4095, 12'd0, 32'd0, 32'd0, 16'd0, 32'd0},
    '{12'd100, 12'd3000, 32'd25, 32'd60, 16'd5, 32'd100},
    '{ON_THR_RST, OFF_THR_RST, ON_DB_RST, OFF_DB_RST, PERIOD_RST, WARN_RST},
    '{12'd1, 12'd0, 32'd1, 32'd1, 16'd1, 32'd1},
    '{12'd0, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF},
    '{12'd3500, 12'd500, 32'd100, 32'd100, 16'd50, 32'd400}
  };
  int unsigned phase_step [NUM_PHASES] = '{20, 3, 10, 4000, 2, 70000, 80};

  // qualifier copy
  cfg_t            qual_cfg = '{ON_THR_RST, OFF_THR_RST, ON_DB_RST, OFF_DB_RST,
                                PERIOD_RST, WARN_RST};
  cls_t            qual_state = CLS_UNKNOWN;
  cls_t            cand_cls   = CLS_UNKNOWN;
  logic [MS_W-1:0] cand_start = '0;
  logic [MS_W-1:0] last_ms    = '0;
  logic [MS_W-1:0] mid_start  = '0;
  logic            mid_run    = 1'b0;
  logic            mid_warned = 1'b0;

  res_t        pending_status [$];
  res_t        oldest;
  int unsigned fails;
  int unsigned offered;
  int unsigned settings_used;
  int unsigned gate_passed;
  int unsigned on_events;
  int unsigned off_events;
  int unsigned warnings;
  bit          no_idle;

  function automatic res_t qualify_sample(input logic [MV_W-1:0] pin,
                                          input logic [MS_W-1:0] now);
    res_t            r;
    cls_t            c;
    logic [MS_W-1:0] elapsed;
    logic [MS_W-1:0] need;
    r = '0;
    elapsed = now - last_ms;
    if (elapsed >= {16'd0, qual_cfg.period_ms}) begin
      r.accepted = 1'b1;
      last_ms = now;
      if (pin >= qual_cfg.on_thr_mv) c = CLS_ON;
      else if (pin <= qual_cfg.off_thr_mv) c = CLS_OFF;
      else c = CLS_UNKNOWN;
      if (c == CLS_UNKNOWN) begin
        elapsed = now - mid_start;
        if (!mid_run) begin
          mid_run = 1'b1;
          mid_start = now;
        end else if (!mid_warned && elapsed >= qual_cfg.warn_ms) begin
          mid_warned = 1'b1;
          r.midzone_warning = 1'b1;
        end
      end else begin
        mid_run = 1'b0;
        mid_start = '0;
        mid_warned = 1'b0;
        if (c != cand_cls) begin
          cand_cls = c;
          cand_start = now;
        end else if (c != qual_state) begin
          need = (c == CLS_ON) ? qual_cfg.on_db_ms : qual_cfg.off_db_ms;
          elapsed = now - cand_start;
          if (elapsed >= need) begin
            qual_state = c;
            r.transition_event = (c == CLS_ON) ? EVT_ON : EVT_OFF;
          end
        end
      end
    end
    r.ignition_state = qual_state;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    in_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ON_THR:  qual_cfg.on_thr_mv  = val[MV_W-1:0];
      REG_OFF_THR: qual_cfg.off_thr_mv = val[MV_W-1:0];
      REG_ON_DB:   qual_cfg.on_db_ms   = val[MS_W-1:0];
      REG_OFF_DB:  qual_cfg.off_db_ms  = val[MS_W-1:0];
      REG_PERIOD:  qual_cfg.period_ms  = val[PER_W-1:0];
      REG_WARN:    qual_cfg.warn_ms    = val[MS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(REG_ON_THR, CFG_DATA_W'(c.on_thr_mv));
    write_reg(REG_OFF_THR, CFG_DATA_W'(c.off_thr_mv));
    write_reg(REG_ON_DB, c.on_db_ms);
    write_reg(REG_OFF_DB, c.off_db_ms);
    write_reg(REG_PERIOD, CFG_DATA_W'(c.period_ms));
    write_reg(REG_WARN, c.warn_ms);
    settings_used++;
  endtask

  task automatic send_item(input logic [MV_W-1:0] pin, input logic [MS_W-1:0] stamp_ms,
                           input logic typed, input res_t want);
    res_t pred;
    while (!no_idle && $urandom_range(99, 0) < 29) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.pin_mv  <= pin;
    in_if.time_ms <= stamp_ms;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pred = qualify_sample(pin, stamp_ms);
    pending_status.push_back(typed ? want : pred);
    offered++;
  endtask

  task automatic flag_field(input string name, input logic [1:0] exp_v,
                            input logic [1:0] got_v);
    $error("%s: expected %0d, got %0d", name, exp_v, got_v);
    fails++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_status.size() == 0) begin
        $error("result item with no expectation waiting");
        fails++;
      end else begin
        oldest = pending_status.pop_front();
        if (oldest.accepted !== out_if.accepted)
          flag_field("accepted", {1'b0, oldest.accepted}, {1'b0, out_if.accepted});
        if (oldest.ignition_state !== out_if.ignition_state)
          flag_field("ignition_state", oldest.ignition_state, out_if.ignition_state);
        if (oldest.transition_event !== out_if.transition_event)
          flag_field("transition_event", oldest.transition_event, out_if.transition_event);
        if (oldest.midzone_warning !== out_if.midzone_warning)
          flag_field("midzone_warning", {1'b0, oldest.midzone_warning},
                     {1'b0, out_if.midzone_warning});
      end
      if (out_if.accepted === 1'b1) gate_passed++;
      if (out_if.transition_event === EVT_ON) on_events++;
      if (out_if.transition_event === EVT_OFF) off_events++;
      if (out_if.midzone_warning === 1'b1) warnings++;
    end
  end

  // result side: random stalls, one long hold-off, one stretch with no stalls
  initial begin
    int unsigned taken;
    bit          held;
    taken = 0;
    held  = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) taken++;
      if (!held && taken >= 480) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (taken >= 650 && taken < 950) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(99, 0) >= 29);
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
    $display("ignition_sense_qualifier_top: mismatch");
    $finish;
  end

  initial begin
    logic [MS_W-1:0] stamp;
    logic [MV_W-1:0] pin;
    cls_t            run_cls;
    int              lo;
    int              hi;
    int unsigned     roll;
    cfg_t            c;
    fails         = 0;
    offered       = 0;
    settings_used = 3;
    gate_passed   = 0;
    on_events     = 0;
    off_events    = 0;
    warnings      = 0;
    no_idle       = 1'b0;
    run_cls       = CLS_ON;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    in_if.valid   <= 1'b0;
    in_if.pin_mv  <= '0;
    in_if.time_ms <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].idx, directed_rows[i].a);
      else
        send_item(directed_rows[i].a[MV_W-1:0], directed_rows[i].b,
                  directed_rows[i].typed, directed_rows[i].want);
    end
    stamp = directed_rows[28].b;

    for (int p = 0; p < NUM_PHASES; p++) begin
      c = phase_cfg[p];
      apply_settings(c);
      repeat (PER_PHASE) begin
        no_idle = (offered >= 600 && offered < 900);
        if ($urandom_range(99, 0) < 20) run_cls = cls_t'($urandom_range(2, 0));
        lo = int'(c.off_thr_mv) + 1;
        hi = int'(c.on_thr_mv) - 1;
        if ($urandom_range(99, 0) < 10) pin = MV_W'($urandom);
        else case (run_cls)
          CLS_ON:  pin = MV_W'($urandom_range(4095, c.on_thr_mv));
          CLS_OFF: pin = MV_W'($urandom_range(c.off_thr_mv, 0));
          default: pin = (hi >= lo) ? MV_W'($urandom_range(hi, lo)) : MV_W'($urandom);
        endcase
        roll = $urandom_range(99, 0);
        if (roll < 65)
          stamp = stamp + MS_W'(c.period_ms) + $urandom_range(phase_step[p], 0);
        else if (roll < 80) stamp = stamp + $urandom_range(c.period_ms, 0);
        else if (roll < 87) stamp = stamp;
        else if (roll < 94) stamp = stamp + $urandom;
        else stamp = stamp - $urandom_range(phase_step[p], 0);
        send_item(pin, stamp, 1'b0, '0);
      end
    end

    in_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d items over %0d register settings, %0d passed the sample gate",
             offered, settings_used, gate_passed);
    $display("%0d engine-on, %0d engine-off events and %0d midzone warnings checked",
             on_events, off_events, warnings);
    if (fails == 0) $display("ignition_sense_qualifier_top: match");
    else $display("ignition_sense_qualifier_top: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

/* ignition_sense_qualifier_top.f */
+incdir+design
design/isq_pkg.sv
design/isq_ifs.sv
design/isq_core.sv
design/ignition_sense_qualifier_top.sv
tb/sv/tb.sv
